FILE: rtl/dpw_pkg.sv
`timescale 1ns / 1ps

package dpw_pkg;

    // configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 63;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_X     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_Y     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRINCIPAL   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_ZERO    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_ONE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_TWO     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANSLATION = 3'd6;

    // register reset values
    localparam logic [31:0] RST_FOCAL_X     = 32'd8180940;
    localparam logic [31:0] RST_FOCAL_Y     = 32'd8180940;
    localparam logic [31:0] RST_PRINCIPAL   = 32'd251139064;
    localparam logic [62:0] RST_ROT_ZERO    = 63'd524288;
    localparam logic [62:0] RST_ROT_ONE     = 63'd1099511627776;
    localparam logic [62:0] RST_ROT_TWO     = 63'd2305843009213693952;
    localparam logic [62:0] RST_TRANSLATION = 63'd0;

    // packed field width of rotation entries and translation
    localparam int COEF_W = 21;

    // accept edge to result strobe, in clock edges
    localparam int PIPE_LATENCY = 10;

    typedef logic signed [COEF_W-1:0] coef_t;

    // input word
    typedef struct packed {
        logic [9:0]  pixel_column;
        logic [8:0]  pixel_row;
        logic [15:0] depth_mm;
        logic        frame_end_in;
    } pixel_t;

    // result word
    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic               frame_end_out;
    } point_t;

    // decoded configuration
    typedef struct packed {
        logic [31:0]           focal_x_recip;
        logic [31:0]           focal_y_recip;
        logic [15:0]           cx;
        logic [15:0]           cy;
        coef_t [2:0][2:0]      rot;
        coef_t [2:0]           trans;
    } cfg_t;

    // camera point between back-projection and transform
    typedef struct packed {
        logic        valid;
        logic        neg_x;
        logic [32:0] qx;
        logic        neg_y;
        logic [32:0] qy;
        logic [15:0] depth;
        logic        frame_end;
    } cam_t;

endpackage

FILE: rtl/dpw_cfg_regs.sv
`timescale 1ns / 1ps

module dpw_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dpw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dpw_pkg::CFG_DATA_W-1:0]    cfg_data,
    output dpw_pkg::cfg_t                     cfg
);

    logic [31:0]                      focal_x_reg;
    logic [31:0]                      focal_y_reg;
    logic [31:0]                      principal_reg;
    logic [dpw_pkg::CFG_DATA_W-1:0]   rot0_reg;
    logic [dpw_pkg::CFG_DATA_W-1:0]   rot1_reg;
    logic [dpw_pkg::CFG_DATA_W-1:0]   rot2_reg;
    logic [dpw_pkg::CFG_DATA_W-1:0]   trans_reg;
    logic [2:0][dpw_pkg::CFG_DATA_W-1:0] rows;

    // register writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg   <= dpw_pkg::RST_FOCAL_X;
            focal_y_reg   <= dpw_pkg::RST_FOCAL_Y;
            principal_reg <= dpw_pkg::RST_PRINCIPAL;
            rot0_reg      <= dpw_pkg::RST_ROT_ZERO;
            rot1_reg      <= dpw_pkg::RST_ROT_ONE;
            rot2_reg      <= dpw_pkg::RST_ROT_TWO;
            trans_reg     <= dpw_pkg::RST_TRANSLATION;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dpw_pkg::REG_FOCAL_X:     focal_x_reg   <= cfg_data[31:0];
                dpw_pkg::REG_FOCAL_Y:     focal_y_reg   <= cfg_data[31:0];
                dpw_pkg::REG_PRINCIPAL:   principal_reg <= cfg_data[31:0];
                dpw_pkg::REG_ROT_ZERO:    rot0_reg      <= cfg_data;
                dpw_pkg::REG_ROT_ONE:     rot1_reg      <= cfg_data;
                dpw_pkg::REG_ROT_TWO:     rot2_reg      <= cfg_data;
                dpw_pkg::REG_TRANSLATION: trans_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign rows = {rot2_reg, rot1_reg, rot0_reg};

    // unpack fields
    always_comb
    begin
        cfg.focal_x_recip = focal_x_reg;
        cfg.focal_y_recip = focal_y_reg;
        cfg.cx            = principal_reg[15:0];
        cfg.cy            = principal_reg[31:16];
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cfg.rot[i][j] = rows[i][dpw_pkg::COEF_W*j +: dpw_pkg::COEF_W];
            end
            cfg.trans[i] = trans_reg[dpw_pkg::COEF_W*i +: dpw_pkg::COEF_W];
        end
    end

`ifndef ASSERT_OFF
    a_focal_x_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == dpw_pkg::REG_FOCAL_X |=>
        focal_x_reg == $past(cfg_data[31:0]))
        else $error("focal x reciprocal write lost");
`endif

endmodule

FILE: rtl/dpw_backproject.sv
`timescale 1ns / 1ps

module dpw_backproject (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  dpw_pkg::pixel_t  pixel,
    input  dpw_pkg::cfg_t    cfg,
    output dpw_pkg::cam_t    cam
);

    // stage 1: offsets from principal point
    logic               s1_valid_reg;
    logic               s1_neg_x_reg;
    logic               s1_neg_y_reg;
    logic [15:0]        s1_mag_x_reg;
    logic [15:0]        s1_mag_y_reg;
    logic [15:0]        s1_depth_reg;
    logic               s1_frame_end_reg;

    // stage 2: offset times depth
    logic               s2_valid_reg;
    logic               s2_neg_x_reg;
    logic               s2_neg_y_reg;
    logic [31:0]        s2_m_x_reg;
    logic [31:0]        s2_m_y_reg;
    logic [15:0]        s2_depth_reg;
    logic               s2_frame_end_reg;

    // stage 3: partial products against the reciprocal halves
    logic               s3_valid_reg;
    logic               s3_neg_x_reg;
    logic               s3_neg_y_reg;
    logic [47:0]        s3_hi_x_reg;
    logic [47:0]        s3_lo_x_reg;
    logic [47:0]        s3_hi_y_reg;
    logic [47:0]        s3_lo_y_reg;
    logic [15:0]        s3_depth_reg;
    logic               s3_frame_end_reg;

    // stage 4: rounded camera magnitudes
    logic               s4_valid_reg;
    logic               s4_neg_x_reg;
    logic               s4_neg_y_reg;
    logic [32:0]        s4_qx_reg;
    logic [32:0]        s4_qy_reg;
    logic [15:0]        s4_depth_reg;
    logic               s4_frame_end_reg;

    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic [15:0]        mag_x_next;
    logic [15:0]        mag_y_next;
    logic [48:0]        sum_x;
    logic [48:0]        sum_y;

    // pixel offsets in Q.4, sign and magnitude
    always_comb
    begin
        dx = $signed({4'b0, pixel.pixel_column, 4'b0}) - $signed({2'b0, cfg.cx});
        dy = $signed({5'b0, pixel.pixel_row, 4'b0}) - $signed({2'b0, cfg.cy});
        mag_x_next = dx[17] ? 16'(-dx) : dx[15:0];
        mag_y_next = dy[17] ? 16'(-dy) : dy[15:0];
    end

    // reciprocal multiply with rounding on the upper half
    always_comb
    begin
        sum_x = {1'b0, s3_hi_x_reg} + 49'h8000 + {17'b0, s3_lo_x_reg[47:16]};
        sum_y = {1'b0, s3_hi_y_reg} + 49'h8000 + {17'b0, s3_lo_y_reg[47:16]};
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        s1_neg_x_reg     <= dx[17];
        s1_neg_y_reg     <= dy[17];
        s1_mag_x_reg     <= mag_x_next;
        s1_mag_y_reg     <= mag_y_next;
        s1_depth_reg     <= pixel.depth_mm;
        s1_frame_end_reg <= pixel.frame_end_in;

        s2_neg_x_reg     <= s1_neg_x_reg;
        s2_neg_y_reg     <= s1_neg_y_reg;
        s2_m_x_reg       <= s1_mag_x_reg * s1_depth_reg;
        s2_m_y_reg       <= s1_mag_y_reg * s1_depth_reg;
        s2_depth_reg     <= s1_depth_reg;
        s2_frame_end_reg <= s1_frame_end_reg;

        s3_neg_x_reg     <= s2_neg_x_reg;
        s3_neg_y_reg     <= s2_neg_y_reg;
        s3_hi_x_reg      <= s2_m_x_reg * cfg.focal_x_recip[31:16];
        s3_lo_x_reg      <= s2_m_x_reg * cfg.focal_x_recip[15:0];
        s3_hi_y_reg      <= s2_m_y_reg * cfg.focal_y_recip[31:16];
        s3_lo_y_reg      <= s2_m_y_reg * cfg.focal_y_recip[15:0];
        s3_depth_reg     <= s2_depth_reg;
        s3_frame_end_reg <= s2_frame_end_reg;

        s4_neg_x_reg     <= s3_neg_x_reg;
        s4_neg_y_reg     <= s3_neg_y_reg;
        s4_qx_reg        <= sum_x[48:16];
        s4_qy_reg        <= sum_y[48:16];
        s4_depth_reg     <= s3_depth_reg;
        s4_frame_end_reg <= s3_frame_end_reg;
    end

    always_comb
    begin
        cam.valid     = s4_valid_reg;
        cam.neg_x     = s4_neg_x_reg;
        cam.qx        = s4_qx_reg;
        cam.neg_y     = s4_neg_y_reg;
        cam.qy        = s4_qy_reg;
        cam.depth     = s4_depth_reg;
        cam.frame_end = s4_frame_end_reg;
    end

`ifndef ASSERT_OFF
    a_zero_depth_origin: assert property (@(posedge clk) disable iff (!rst_n)
        cam.valid && cam.depth == 16'd0 |-> cam.qx == 33'd0 && cam.qy == 33'd0)
        else $error("zero depth gave nonzero camera point");
`endif

endmodule

FILE: rtl/dpw_transform.sv
`timescale 1ns / 1ps

module dpw_transform (
    input  logic             clk,
    input  logic             rst_n,
    input  dpw_pkg::cam_t    cam,
    input  dpw_pkg::cfg_t    cfg,
    output logic             done,
    output dpw_pkg::point_t  point
);

    localparam int PROD_W = 56;
    localparam int ACC_W  = 58;
    localparam int MAG_W  = 57;
    localparam int RND_W  = 39;
    localparam int W_W    = 41;
    localparam logic signed [W_W-1:0] SAT_MAX = W_W'(64'sd2147483647);
    localparam logic signed [W_W-1:0] SAT_MIN = W_W'(-64'sd2147483648);

    // stage 5: rotation products
    logic                     s5_valid_reg;
    logic                     s5_frame_end_reg;
    logic signed [PROD_W-1:0] s5_prod_reg [0:2][0:2];

    // stage 6: row sums
    logic                     s6_valid_reg;
    logic                     s6_frame_end_reg;
    logic signed [ACC_W-1:0]  s6_acc_reg [0:2];

    // stage 7: sign and magnitude
    logic                     s7_valid_reg;
    logic                     s7_frame_end_reg;
    logic                     s7_neg_reg [0:2];
    logic [MAG_W-1:0]         s7_mag_reg [0:2];

    // stage 8: rounded shift
    logic                     s8_valid_reg;
    logic                     s8_frame_end_reg;
    logic                     s8_neg_reg [0:2];
    logic [RND_W-1:0]         s8_rnd_reg [0:2];

    // stage 9: translation added
    logic                     s9_valid_reg;
    logic                     s9_frame_end_reg;
    logic signed [W_W-1:0]    s9_w_reg [0:2];

    // stage 10: saturated output word
    logic                     done_reg;
    logic signed [31:0]       out_reg [0:2];
    logic                     out_frame_end_reg;

    logic signed [21:0]       coef_x [0:2];
    logic signed [21:0]       coef_y [0:2];
    logic signed [33:0]       qx_s;
    logic signed [33:0]       qy_s;
    logic signed [20:0]       zc;
    logic signed [PROD_W-1:0] prod_next [0:2][0:2];
    logic signed [ACC_W-1:0]  acc_next [0:2];
    logic [MAG_W-1:0]         mag_next [0:2];
    logic [MAG_W:0]           rsum [0:2];
    logic signed [24:0]       t16 [0:2];
    logic signed [W_W-1:0]    w_next [0:2];
    logic signed [31:0]       sat_next [0:2];

    // camera sign folded into the coefficient
    always_comb
    begin
        qx_s = $signed({1'b0, cam.qx});
        qy_s = $signed({1'b0, cam.qy});
        zc   = -$signed({1'b0, cam.depth, 4'b0});
        for (int i = 0; i < 3; i++)
        begin
            coef_x[i] = 22'($signed(cfg.rot[i][0]));
            coef_y[i] = 22'($signed(cfg.rot[i][1]));
            if (cam.neg_x)
            begin
                coef_x[i] = -coef_x[i];
            end
            if (cam.neg_y)
            begin
                coef_y[i] = -coef_y[i];
            end
            prod_next[i][0] = coef_x[i] * qx_s;
            prod_next[i][1] = coef_y[i] * qy_s;
            prod_next[i][2] = $signed(cfg.rot[i][2]) * zc;
        end
    end

    // sums, magnitudes, rounding, translation and clamp per row
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i] = ACC_W'(s5_prod_reg[i][0]) + ACC_W'(s5_prod_reg[i][1])
                        + ACC_W'(s5_prod_reg[i][2]);
            mag_next[i] = s6_acc_reg[i][ACC_W-1] ? MAG_W'(-s6_acc_reg[i])
                                                 : MAG_W'(s6_acc_reg[i]);
            rsum[i]     = {1'b0, s7_mag_reg[i]} + (MAG_W+1)'(1 << 18);
            t16[i]      = 25'($signed(cfg.trans[i])) <<< 4;
            if (s8_neg_reg[i])
            begin
                w_next[i] = W_W'(t16[i]) - $signed({2'b0, s8_rnd_reg[i]});
            end
            else
            begin
                w_next[i] = W_W'(t16[i]) + $signed({2'b0, s8_rnd_reg[i]});
            end
            if (s9_w_reg[i] > SAT_MAX)
            begin
                sat_next[i] = 32'sh7fffffff;
            end
            else if (s9_w_reg[i] < SAT_MIN)
            begin
                sat_next[i] = 32'sh80000000;
            end
            else
            begin
                sat_next[i] = s9_w_reg[i][31:0];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= cam.valid;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
            done_reg     <= s9_valid_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        s5_frame_end_reg  <= cam.frame_end;
        s6_frame_end_reg  <= s5_frame_end_reg;
        s7_frame_end_reg  <= s6_frame_end_reg;
        s8_frame_end_reg  <= s7_frame_end_reg;
        s9_frame_end_reg  <= s8_frame_end_reg;
        out_frame_end_reg <= s9_frame_end_reg;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s5_prod_reg[i][j] <= prod_next[i][j];
            end
            s6_acc_reg[i] <= acc_next[i];
            s7_neg_reg[i] <= s6_acc_reg[i][ACC_W-1];
            s7_mag_reg[i] <= mag_next[i];
            s8_neg_reg[i] <= s7_neg_reg[i];
            s8_rnd_reg[i] <= rsum[i][19 +: RND_W];
            s9_w_reg[i]   <= w_next[i];
            out_reg[i]    <= sat_next[i];
        end
    end

    assign done = done_reg;

    always_comb
    begin
        point.world_x       = out_reg[0];
        point.world_y       = out_reg[1];
        point.world_z       = out_reg[2];
        point.frame_end_out = out_frame_end_reg;
    end

`ifndef ASSERT_OFF
    a_clamp_high: assert property (@(posedge clk) disable iff (!rst_n)
        s9_valid_reg && s9_w_reg[0] > SAT_MAX |=> point.world_x == 32'sh7fffffff)
        else $error("x coordinate not clamped");
`endif

endmodule

FILE: rtl/depth_pixel_to_world_point.sv
`timescale 1ns / 1ps

// Depth pixel to world point.
// Input: a pixel word (column, row, depth in mm, frame end) is taken at each
// rising edge with start high and busy low. busy stays low: a new pixel may
// be offered every cycle, one word per clock is sustained.
// Output: done pulses for one cycle with the world point word on point
// (x, y, z in 1/16 mm, saturated to 32 bits, frame end copied). Each word
// passes through ten register stages: offsets, depth multiply, reciprocal
// partial products, rounding, rotation products, row sums, magnitude,
// rounded shift, translation add and clamp; done is registered alongside
// the clamped word. There is no back-pressure; the receiver must take
// every word in the cycle it is shown.
// Configuration: cfg_we writes cfg_data to register cfg_index on a clock edge;
// unknown indexes are dropped. Write only while no pixel is in flight.
// Reset: asynchronous, clears all pipeline valid bits (no result is shown)
// and restores identity rotation, zero translation, default intrinsics.
module depth_pixel_to_world_point (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  dpw_pkg::pixel_t                   pixel,
    input  logic                              cfg_we,
    input  logic [dpw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dpw_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              done,
    output dpw_pkg::point_t                   point
);

    dpw_pkg::cfg_t cfg;
    dpw_pkg::cam_t cam;

    // never stalls
    assign busy = 1'b0;

    // configuration registers
    dpw_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // pinhole back-projection
    dpw_backproject u_backproject (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .pixel    (pixel),
        .cfg      (cfg),
        .cam      (cam)
    );

    // rigid transform, rounding and clamp
    dpw_transform u_transform (
        .clk   (clk),
        .rst_n (rst_n),
        .cam   (cam),
        .cfg   (cfg),
        .done  (done),
        .point (point)
    );

`ifndef ASSERT_OFF
    a_every_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(dpw_pkg::PIPE_LATENCY) done)
        else $error("accepted word produced no result");

    a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, dpw_pkg::PIPE_LATENCY))
        else $error("result without accepted word");

    a_frame_end_kept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && pixel.frame_end_in |->
        ##(dpw_pkg::PIPE_LATENCY) point.frame_end_out)
        else $error("frame end marker lost");
`endif

endmodule
